// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the URL percent decoder RTL.
// Included by the modules that carry concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checked only while out of reset.
`define UPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define UPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define UPD_ASSERT(label, prop, msg)
`define UPD_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ===== hdl/upd_pkg.sv =====
// Types, character codes, phase codes and decode helpers for the URL percent decoder.
// No dependencies; used by every module and the testbench.
package upd_pkg;

  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] Char0     = 8'h30;
  localparam logic [7:0] Char9     = 8'h39;
  localparam logic [7:0] CharLa    = 8'h61;
  localparam logic [7:0] CharLf    = 8'h66;
  localparam logic [7:0] CharUa    = 8'h41;
  localparam logic [7:0] CharUf    = 8'h46;

  // Escape phase codes
  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhPct  = 2'd1;
  localparam logic [1:0] PhHeld = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } upd_req_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] val;
  } upd_hex_t;

  function automatic upd_hex_t hex_digit(input logic [7:0] c);
    upd_hex_t   h;
    logic [7:0] d;
    h.hit = 1'b0;
    h.val = 4'd0;
    d     = 8'd0;
    if (c >= Char0 && c <= Char9) begin
      d = c - Char0;
      h.hit = 1'b1;
    end else if (c >= CharLa && c <= CharLf) begin
      d = c - CharLa + 8'd10;
      h.hit = 1'b1;
    end else if (c >= CharUa && c <= CharUf) begin
      d = c - CharUa + 8'd10;
      h.hit = 1'b1;
    end
    h.val = d[3:0];
    return h;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CharSpace) || (c >= CharTab && c <= CharCr);
  endfunction

  // Value of a two-byte escape, read as a base-16 number with one optional
  // leading blank or plus sign; zero means nothing to emit.
  function automatic logic [7:0] escape_value(input logic [7:0] c1, input logic [7:0] c2);
    upd_hex_t h1;
    upd_hex_t h2;
    logic [7:0] v;
    h1 = hex_digit(c1);
    h2 = hex_digit(c2);
    v  = 8'd0;
    if (h1.hit && h2.hit) begin
      v = {h1.val, h2.val};
    end else if (h1.hit) begin
      v = {4'd0, h1.val};
    end else if ((is_space(c1) || c1 == CharPlus) && h2.hit) begin
      v = {4'd0, h2.val};
    end
    return v;
  endfunction

endpackage

// ===== hdl/upd_channels.sv =====
// Valid/ready channel interfaces for the URL percent decoder request and result streams.
// Depends on nothing but plain logic types.
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  modport source (output valid, output out_byte, output out_valid, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input out_valid, input out_last,
                  output ready);
endinterface

// ===== hdl/upd_in_stage.sv =====
// Input register of the URL percent decoder: captures one request per cycle while the core takes them.
// Depends on upd_pkg and upd_in_if.
module upd_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  upd_in_if.sink            in_i,
  output logic              req_valid_o,
  output upd_pkg::upd_req_t req_o,
  input  logic              req_ready_i
);

  logic              valid_q;
  logic              valid_d;
  upd_pkg::upd_req_t req_q;
  logic              in_fire;

  assign in_i.ready = !valid_q || req_ready_i;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (in_fire) begin
      valid_d = 1'b1;
    end else if (req_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q.in_byte <= in_i.in_byte;
      req_q.in_last <= in_i.in_last;
    end
  end

  assign req_valid_o = valid_q;
  assign req_o       = req_q;

endmodule

// ===== hdl/upd_core.sv =====
// Escape phase tracking, byte decode and result register of the URL percent decoder.
// Depends on upd_pkg, upd_out_if and assert_macros.svh.
`include "assert_macros.svh"

module upd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  upd_pkg::upd_req_t req_i,
  output logic              req_ready_o,
  upd_out_if.source         out_o
);

  logic [1:0] phase_q;
  logic [1:0] phase_d;
  logic [7:0] held_q;
  logic       out_vld_q;
  logic       out_vld_d;
  logic [7:0] byte_q;
  logic [7:0] byte_d;
  logic       flag_q;
  logic       flag_d;
  logic       last_q;
  logic       fire;
  logic [7:0] esc;

  assign req_ready_o = !out_vld_q || out_o.ready;
  assign fire        = req_valid_i && req_ready_o;
  assign esc         = upd_pkg::escape_value(held_q, req_i.in_byte);

  always_comb begin
    phase_d = upd_pkg::PhIdle;
    byte_d  = 8'd0;
    flag_d  = 1'b0;
    case (phase_q)
      upd_pkg::PhPct: begin
        phase_d = upd_pkg::PhHeld;
      end
      upd_pkg::PhHeld: begin
        // emit only a nonzero escape value
        if (esc != 8'd0) begin
          byte_d = esc;
          flag_d = 1'b1;
        end
      end
      default: begin
        if (req_i.in_byte == upd_pkg::CharPlus) begin
          byte_d = upd_pkg::CharSpace;
          flag_d = 1'b1;
        end else if (req_i.in_byte == upd_pkg::CharPct) begin
          phase_d = upd_pkg::PhPct;
        end else begin
          byte_d = req_i.in_byte;
          flag_d = 1'b1;
        end
      end
    endcase
    // end of string drops any open escape
    if (req_i.in_last) begin
      phase_d = upd_pkg::PhIdle;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (fire) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= upd_pkg::PhIdle;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (fire) begin
        phase_q <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && phase_q == upd_pkg::PhPct) begin
      held_q <= req_i.in_byte;
    end
    if (fire) begin
      byte_q <= byte_d;
      flag_q <= flag_d;
      last_q <= req_i.in_last;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.out_byte  = byte_q;
  assign out_o.out_valid = flag_q;
  assign out_o.out_last  = last_q;

  `UPD_ASSERT(a_last_closes, fire && req_i.in_last |=> phase_q == upd_pkg::PhIdle, "escape open after last byte")
  `UPD_ASSERT(a_pct_to_held, fire && phase_q == upd_pkg::PhPct && !req_i.in_last |=> phase_q == upd_pkg::PhHeld, "first escape byte not held")
  `UPD_ASSERT(a_held_closes, fire && phase_q == upd_pkg::PhHeld |=> phase_q == upd_pkg::PhIdle, "escape not closed after second byte")
  `UPD_ASSERT(a_plain_emits, fire && phase_q == upd_pkg::PhIdle && req_i.in_byte != upd_pkg::CharPct |=> out_o.valid && out_o.out_valid, "plain byte not emitted")
  `UPD_ASSERT(a_empty_zero, out_o.valid && !out_o.out_valid |-> out_o.out_byte == 8'd0, "empty result carries a byte")

endmodule

// ===== hdl/url_percent_decoder.sv =====
// URL percent decoder: one encoded byte in and one result out per cycle; each request passes
// the input register and then the result register. The rate is set by these two registers,
// each of which refills in the cycle it drains; the escape phase register updates on every
// accepted request, so a stall on the result side is the only thing that slows intake.
// Every request yields exactly one result; out_valid says whether it carries a decoded byte.
// Depends on upd_pkg, the channel interfaces, upd_in_stage and upd_core.
module url_percent_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  upd_in_if.sink    in_i,
  upd_out_if.source out_o
);

  logic              req_valid;
  logic              req_ready;
  upd_pkg::upd_req_t req;

  upd_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_ready_i (req_ready)
  );

  upd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_ready_o (req_ready),
    .out_o       (out_o)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for url_percent_decoder: drives encoded strings, predicts decoded bytes.
// Depends on upd_pkg and the upd_in_if / upd_out_if channel interfaces.
module testbench;

  typedef struct packed {
    logic [7:0] enc_byte;
    logic       enc_last;
  } enc_item_t;

  typedef struct packed {
    logic [7:0] dec_byte;
    logic       dec_valid;
    logic       dec_last;
  } dec_item_t;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned LongHoldCycles = 200;
  localparam int unsigned LongHoldAt = 1450;
  localparam int unsigned RandomItems = 1600;
  localparam logic [7:0] CharMinus = 8'h2D;

  logic clk_i;
  logic rst_ni;

  upd_in_if  in_if ();
  upd_out_if out_if ();

  url_percent_decoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  enc_item_t   enc_bytes_q[$];
  dec_item_t   decoded_q[$];
  logic [1:0]  esc_phase;
  logic [7:0]  esc_first;
  int unsigned req_count;
  int unsigned err_count;
  int unsigned idle_cycles;
  int unsigned hold_left;
  logic        hold_done;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Idle rates in percent, stepped by how far the request stream has got.
  function automatic int unsigned tx_idle_pct(input int unsigned n);
    if (n < 550) return 36;
    if (n < 1100) return 50;
    return 0;
  endfunction

  function automatic int unsigned rx_idle_pct(input int unsigned n);
    if (n < 550) return 50;
    if (n < 1100) return 36;
    return 0;
  endfunction

  function automatic logic hex_ok(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
      return 1'b1;
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h61 + 8'd10);
      return 1'b1;
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h41 + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the decoder state by one request and return the result it should give.
  function automatic dec_item_t decode_next(input enc_item_t it);
    dec_item_t  r;
    logic [3:0] v1;
    logic [3:0] v2;
    logic       h1;
    logic       h2;
    logic [7:0] val;
    r = '0;
    r.dec_last = it.enc_last;
    if (esc_phase == upd_pkg::PhPct) begin
      esc_first = it.enc_byte;
      esc_phase = upd_pkg::PhHeld;
    end else if (esc_phase == upd_pkg::PhHeld) begin
      h1 = hex_ok(esc_first, v1);
      h2 = hex_ok(it.enc_byte, v2);
      val = 8'd0;
      if (h1 && h2) val = {v1, v2};
      else if (h1) val = {4'd0, v1};
      else if ((esc_first == 8'h20 || (esc_first >= 8'h09 && esc_first <= 8'h0D) ||
                esc_first == upd_pkg::CharPlus) && h2) val = {4'd0, v2};
      if (val != 8'd0) begin
        r.dec_byte = val;
        r.dec_valid = 1'b1;
      end
      esc_phase = upd_pkg::PhIdle;
    end else begin
      esc_phase = upd_pkg::PhIdle;
      if (it.enc_byte == upd_pkg::CharPlus) begin
        r.dec_byte = upd_pkg::CharSpace;
        r.dec_valid = 1'b1;
      end else if (it.enc_byte == upd_pkg::CharPct) begin
        esc_phase = upd_pkg::PhPct;
      end else begin
        r.dec_byte = it.enc_byte;
        r.dec_valid = 1'b1;
      end
    end
    if (it.enc_last) esc_phase = upd_pkg::PhIdle;
    return r;
  endfunction

  function automatic logic [7:0] rand_hex();
    int unsigned d;
    d = $urandom_range(0, 15);
    if (d < 10) return upd_pkg::Char0 + 8'(d);
    return ($urandom_range(0, 1) ? upd_pkg::CharLa : upd_pkg::CharUa) + 8'(d - 10);
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] c;
    c = 8'($urandom_range(32, 126));
    if (c == upd_pkg::CharPct) c = 8'h7E;
    return c;
  endfunction

  function automatic logic [7:0] rand_noise();
    case ($urandom_range(0, 7))
      0, 1: return upd_pkg::CharPct;
      2: return rand_hex();
      3: return upd_pkg::CharPlus;
      4: return 8'($urandom_range(9, 13));
      5: return CharMinus;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Append one encoded byte to the pending request queue.
  task automatic queue_byte(input logic [7:0] b, input logic l);
    enc_item_t it;
    it.enc_byte = b;
    it.enc_last = l;
    enc_bytes_q = {enc_bytes_q, it};
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      queue_byte(s[i], (i == s.len() - 1));
    end
  endtask

  // Build one random string: mostly well-formed, the rest noise or cut-off escapes.
  task automatic push_random_string(output int unsigned n);
    logic [7:0] buf_q[$];
    int unsigned len;
    int unsigned kind;
    len = $urandom_range(1, 10);
    kind = $urandom_range(0, 9);
    buf_q = {};
    while (buf_q.size() < len) begin
      if (kind >= 7) begin
        buf_q = {buf_q, rand_noise()};
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: buf_q = {buf_q, rand_plain()};
          3: buf_q = {buf_q, upd_pkg::CharPlus};
          4: buf_q = {buf_q, 8'($urandom_range(0, 255))};
          5: begin
            buf_q = {buf_q, upd_pkg::CharPct};
            buf_q = {buf_q, ($urandom_range(0, 1) ? upd_pkg::CharPlus :
                             8'($urandom_range(9, 13)))};
            buf_q = {buf_q, rand_hex()};
          end
          default: begin
            buf_q = {buf_q, upd_pkg::CharPct};
            buf_q = {buf_q, rand_hex()};
            buf_q = {buf_q, rand_hex()};
          end
        endcase
      end
    end
    // Cut the string inside an escape now and then.
    if (kind == 6) begin
      buf_q = {buf_q, upd_pkg::CharPct};
      if ($urandom_range(0, 1)) buf_q = {buf_q, rand_hex()};
    end
    n = buf_q.size();
    for (int i = 0; i < buf_q.size(); i++) begin
      queue_byte(buf_q[i], (i == buf_q.size() - 1));
    end
  endtask

  // Request driver: hold the payload until it is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (enc_bytes_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct(req_count)) begin
        in_if.valid <= 1'b1;
        {in_if.in_byte, in_if.in_last} <= enc_bytes_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold-off while requests keep coming.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && req_count >= LongHoldAt) begin
      out_if.ready <= 1'b0;
      hold_left <= LongHoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct(req_count));
    end
  end

  // Monitor: predict on each request, check each result against the oldest prediction.
  always @(posedge clk_i) begin
    dec_item_t want;
    dec_item_t pred;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        pred = decode_next('{enc_byte: in_if.in_byte, enc_last: in_if.in_last});
        decoded_q = {decoded_q, pred};
        req_count <= req_count + 1;
      end
      if (out_if.valid && out_if.ready) begin
        if (decoded_q.size() == 0) begin
          if (err_count < 10) $display("ERROR: result with nothing expected: byte %02h v %b l %b",
                                       out_if.out_byte, out_if.out_valid, out_if.out_last);
          err_count <= err_count + 1;
        end else begin
          want = decoded_q.pop_front();
          if (out_if.out_valid !== want.dec_valid || out_if.out_last !== want.dec_last ||
              out_if.out_byte !== want.dec_byte) begin
            if (err_count < 10) begin
              $display("ERROR: expected byte %02h v %b l %b, got byte %02h v %b l %b",
                       want.dec_byte, want.dec_valid, want.dec_last,
                       out_if.out_byte, out_if.out_valid, out_if.out_last);
            end
            err_count <= err_count + 1;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned total;
    int unsigned n;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.in_byte = 8'd0;
    in_if.in_last = 1'b0;
    out_if.ready = 1'b0;
    esc_phase = upd_pkg::PhIdle;
    esc_first = 8'd0;
    req_count = 0;
    err_count = 0;
    idle_cycles = 0;

    // Directed: plus, full escape, lone first digit, blank and plus skip, sign,
    // escape bytes that are themselves '%', cut-off escapes, extreme bytes.
    push_str("+");
    push_str("%41");
    push_str("%4g");
    push_str("% A");
    push_str("%+f");
    push_str("%-1");
    push_str("%%%");
    push_str("%");
    push_str("%4");
    push_str("%\tF");
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);

    total = 0;
    while (total < RandomItems) begin
      push_random_string(n);
      total += n;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (enc_bytes_q.size() != 0 || in_if.valid || decoded_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (err_count == 0 && decoded_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
